### sv/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

   localparam int CSR_WIDTH   = 5;
   localparam int COUNT_WIDTH = 32;

   localparam logic [CSR_WIDTH-1:0]   FRAMES_RESET = 5'd16;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic hit;
      logic evict;
   } lrupr_status_type;

endpackage

### sv/lrupr_frame_table.sv
`timescale 1ns / 1ps

module lrupr_frame_table
   import lrupr_pkg::*;
#(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 update,
   input  logic [PAGE_BITS-1:0] page,
   input  logic [CSR_WIDTH-1:0] frames_in_use,
   output lrupr_status_type     status,
   output logic [PAGE_BITS-1:0] evicted_page
);

   localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int LIM_W  = ((CNT_W > CSR_WIDTH) ? CNT_W : CSR_WIDTH) + 1;

   logic [PAGE_BITS-1:0]  frame_page_ff [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] frame_valid_ff, frame_valid_in;
   logic [RANK_W-1:0]     frame_rank_ff [MAX_FRAMES];
   logic [RANK_W-1:0]     frame_rank_in [MAX_FRAMES];
   logic [CNT_W-1:0]      resident_ff, resident_in;

   logic [MAX_FRAMES-1:0] match;
   logic [MAX_FRAMES-1:0] victim;
   logic [MAX_FRAMES-1:0] free_frames;
   logic [MAX_FRAMES-1:0] first_free;
   logic [MAX_FRAMES-1:0] load;
   logic [RANK_W-1:0]     hit_rank;
   logic [RANK_W-1:0]     oldest;
   logic [RANK_W-1:0]     bound;
   logic [PAGE_BITS-1:0]  victim_page;
   logic [LIM_W-1:0]      csr_ext;
   logic [LIM_W-1:0]      limit;
   logic                  hit;
   logic                  room;
   logic                  insert;
   logic                  evict;

   always_comb begin
      csr_ext = LIM_W'(frames_in_use);
      if (csr_ext == '0) begin
         limit = LIM_W'(1);
      end else if (csr_ext > LIM_W'(MAX_FRAMES)) begin
         limit = LIM_W'(MAX_FRAMES);
      end else begin
         limit = csr_ext;
      end
   end

   always_comb begin
      oldest = RANK_W'(resident_ff - CNT_W'(1));
      hit_rank = '0;
      victim_page = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match[i]  = frame_valid_ff[i] && (frame_page_ff[i] == page);
         victim[i] = frame_valid_ff[i] && (frame_rank_ff[i] == oldest);
         if (match[i]) begin
            hit_rank = hit_rank | frame_rank_ff[i];
         end
         if (victim[i]) begin
            victim_page = victim_page | frame_page_ff[i];
         end
      end
      free_frames = ~frame_valid_ff;
      first_free  = free_frames & (~free_frames + MAX_FRAMES'(1));
      hit    = |match;
      room   = LIM_W'(resident_ff) < limit;
      insert = !hit && room;
      evict  = !hit && !room;
      bound  = hit ? hit_rank : oldest;
      load   = ({MAX_FRAMES{insert}} & first_free) | ({MAX_FRAMES{evict}} & victim);
   end

   always_comb begin
      frame_valid_in = frame_valid_ff;
      resident_in    = resident_ff;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         frame_rank_in[i] = frame_rank_ff[i];
      end
      if (update) begin
         for (int i = 0; i < MAX_FRAMES; i++) begin
            if (frame_valid_ff[i] && (insert || (frame_rank_ff[i] < bound))) begin
               frame_rank_in[i] = frame_rank_ff[i] + RANK_W'(1);
            end
            if (match[i] || load[i]) begin
               frame_rank_in[i] = '0;
            end
         end
         if (insert) begin
            frame_valid_in = frame_valid_ff | first_free;
            resident_in    = resident_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         resident_ff    <= '0;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            frame_rank_ff[i] <= '0;
         end
      end else begin
         frame_valid_ff <= frame_valid_in;
         resident_ff    <= resident_in;
         for (int i = 0; i < MAX_FRAMES; i++) begin
            frame_rank_ff[i] <= frame_rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (update && load[i]) begin
            frame_page_ff[i] <= page;
         end
      end
   end

   assign status.hit   = hit;
   assign status.evict = evict;
   assign evicted_page = evict ? victim_page : '0;

endmodule

### sv/lru_page_replacement.sv
`timescale 1ns / 1ps

// Fully associative LRU page tracker. Each request on the req_ channel carries one page
// number; each response on the rsp_ channel reports whether the page was resident, the
// page evicted to make room (if any), and the running hit and request counts, which
// saturate at their maximum.
// A request is held in an input register and resolved by a parallel tag compare over all
// frames; the response lands in an output register that drives rsp_tvalid. One request is
// taken every cycle while the receiver keeps up. If the receiver stalls, the response is
// held and the input register keeps at most one further request; req_tready drops only
// while both are occupied. Reset empties all frames, clears both counts and sets the frame
// limit to 16. The user must write the frame limit through csr_wr_en and csr_wr_data
// only while no request is in flight; the block does not enforce this. Zero acts as one
// frame and values above MAX_FRAMES act as MAX_FRAMES.

module lru_page_replacement
   import lrupr_pkg::*;
#(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 20,
   localparam int REQ_WIDTH = ((PAGE_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = PAGE_BITS + 2 * COUNT_WIDTH,
   localparam int RSP_WIDTH = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // page_number
   input  logic [REQ_WIDTH-1:0]   req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // evicted_page, hit_count, reference_count
   output logic [RSP_WIDTH-1:0]   rsp_tdata,
   // hit, evicted_valid
   output logic [1:0]             rsp_tuser,
   input  logic                   csr_wr_en,
   input  logic [CSR_WIDTH-1:0]   csr_wr_data
);

   logic                   in_valid_ff, in_valid_in;
   logic [PAGE_BITS-1:0]   in_page_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff;
   logic                   rsp_evict_ff;
   logic [PAGE_BITS-1:0]   rsp_page_ff;
   logic [COUNT_WIDTH-1:0] rsp_hits_ff;
   logic [COUNT_WIDTH-1:0] rsp_refs_ff;
   logic [CSR_WIDTH-1:0]   frames_ff;
   logic [COUNT_WIDTH-1:0] hit_total_ff, hit_total_in;
   logic [COUNT_WIDTH-1:0] ref_total_ff, ref_total_in;

   logic                   fire;
   logic                   req_take;
   lrupr_status_type       status;
   logic [PAGE_BITS-1:0]   evicted_page;

   lrupr_frame_table #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_frames (
      .clock         (clock),
      .reset         (reset),
      .update        (fire),
      .page          (in_page_ff),
      .frames_in_use (frames_ff),
      .status        (status),
      .evicted_page  (evicted_page)
   );

   always_comb begin
      fire        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
      req_tready  = !in_valid_ff || fire;
      req_take    = req_tvalid && req_tready;
      in_valid_in = req_take || (in_valid_ff && !fire);
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);
      hit_total_in = hit_total_ff;
      ref_total_in = ref_total_ff;
      if (fire) begin
         if (ref_total_ff != COUNT_MAX) begin
            ref_total_in = ref_total_ff + COUNT_WIDTH'(1);
         end
         if (status.hit && (hit_total_ff != COUNT_MAX)) begin
            hit_total_in = hit_total_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         frames_ff    <= FRAMES_RESET;
         hit_total_ff <= '0;
         ref_total_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_total_ff <= hit_total_in;
         ref_total_ff <= ref_total_in;
         if (csr_wr_en) begin
            frames_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_page_ff <= req_tdata[PAGE_BITS-1:0];
      end
      if (fire) begin
         rsp_hit_ff   <= status.hit;
         rsp_evict_ff <= status.evict;
         rsp_page_ff  <= evicted_page;
         rsp_hits_ff  <= hit_total_in;
         rsp_refs_ff  <= ref_total_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_evict_ff, rsp_hit_ff};
   assign rsp_tdata  = RSP_WIDTH'({rsp_refs_ff, rsp_hits_ff, rsp_page_ff});

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import lrupr_pkg::*;

   localparam int FRAMES    = 16;
   localparam int PAGE_W    = 20;
   localparam int REQ_BITS  = 24;
   localparam int RSP_BITS  = 88;
   localparam int SETTLE    = 4;
   localparam int SET_MAX   = 20;

   typedef logic [PAGE_W-1:0] page_type;

   typedef struct packed {
      lrupr_status_type          status;
      page_type                  evicted_page;
      logic [COUNT_WIDTH-1:0]    hit_count;
      logic [COUNT_WIDTH-1:0]    request_count;
   } lookup_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_BITS-1:0]   req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_BITS-1:0]   rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_WIDTH-1:0]  csr_wr_data = '0;

   lru_page_replacement uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the page frames.
   logic [CSR_WIDTH-1:0]   frame_limit_reg = FRAMES_RESET;
   page_type               shadow_page [FRAMES];
   logic                   shadow_valid [FRAMES];
   int unsigned            shadow_rank [FRAMES];
   int unsigned            shadow_resident = 0;
   logic [COUNT_WIDTH-1:0] shadow_hits = '0;
   logic [COUNT_WIDTH-1:0] shadow_requests = '0;

   lookup_type pending_lookups [$];

   int mismatches = 0;
   int responses_checked = 0;
   int hits_seen = 0;
   int evictions_seen = 0;
   int limits_written = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < FRAMES; i++) begin
         shadow_page[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i] = 0;
      end
   end

   function automatic logic [COUNT_WIDTH-1:0] sat_bump(logic [COUNT_WIDTH-1:0] v);
      return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
   endfunction

   function automatic void age_ranks_below(int unsigned bound);
      for (int i = 0; i < FRAMES; i++) begin
         if (shadow_valid[i] && shadow_rank[i] < bound) begin
            shadow_rank[i]++;
         end
      end
   endfunction

   function automatic lookup_type predict_lookup(page_type page);
      lookup_type  r;
      int          found;
      int          slot;
      int          victim;
      int unsigned oldest;
      int unsigned limit;
      r = '0;
      found = -1;
      slot = -1;
      victim = -1;
      oldest = 0;
      limit = int'(frame_limit_reg);
      if (limit == 0) begin
         limit = 1;
      end
      if (limit > FRAMES) begin
         limit = FRAMES;
      end
      shadow_requests = sat_bump(shadow_requests);
      for (int i = 0; i < FRAMES; i++) begin
         if (found < 0 && shadow_valid[i] && shadow_page[i] == page) begin
            found = i;
         end
      end
      if (found >= 0) begin
         age_ranks_below(shadow_rank[found]);
         shadow_rank[found] = 0;
         r.status.hit = 1'b1;
         shadow_hits = sat_bump(shadow_hits);
      end else if (shadow_resident < limit) begin
         for (int i = 0; i < FRAMES; i++) begin
            if (slot < 0 && !shadow_valid[i]) begin
               slot = i;
            end
         end
         if (slot >= 0) begin
            age_ranks_below(32'hFFFF_FFFF);
            shadow_valid[slot] = 1'b1;
            shadow_page[slot] = page;
            shadow_rank[slot] = 0;
            shadow_resident++;
         end
      end else begin
         for (int i = 0; i < FRAMES; i++) begin
            if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > oldest)) begin
               victim = i;
               oldest = shadow_rank[i];
            end
         end
         if (victim >= 0) begin
            r.status.evict = 1'b1;
            r.evicted_page = shadow_page[victim];
            age_ranks_below(oldest);
            shadow_page[victim] = page;
            shadow_rank[victim] = 0;
         end
      end
      r.hit_count = shadow_hits;
      r.request_count = shadow_requests;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Response checker.
   int          rx_run = 0;
   int          rx_mode = 0;
   lookup_type  want_lookup;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_tdata[51:20], 0);
         end else begin
            want_lookup = pending_lookups.pop_front();
            responses_checked++;
            if (rsp_tuser[0]) hits_seen++;
            if (rsp_tuser[1]) evictions_seen++;
            if (rsp_tuser[0] !== want_lookup.status.hit)
               report_mismatch("hit", rsp_tuser[0], want_lookup.status.hit);
            if (rsp_tuser[1] !== want_lookup.status.evict)
               report_mismatch("evicted_valid", rsp_tuser[1], want_lookup.status.evict);
            if (rsp_tdata[19:0] !== want_lookup.evicted_page)
               report_mismatch("evicted_page", rsp_tdata[19:0], want_lookup.evicted_page);
            if (rsp_tdata[51:20] !== want_lookup.hit_count)
               report_mismatch("hit_count", rsp_tdata[51:20], want_lookup.hit_count);
            if (rsp_tdata[83:52] !== want_lookup.request_count)
               report_mismatch("reference_count", rsp_tdata[83:52], want_lookup.request_count);
         end
      end
   end

   // The receiver alternates between steady acceptance, long stalls and random backpressure.
   always @(posedge clock) begin
      if (rx_run == 0) begin
         rx_mode <= int'($urandom_range(0, 2));
         rx_run <= int'($urandom_range(1, 40));
      end else begin
         rx_run <= rx_run - 1;
      end
      case (rx_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'b0;
         end
         default: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
      endcase
   end

   task automatic send_page(page_type page);
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_BITS-PAGE_W){1'b0}}, page};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_lookups.insert(pending_lookups.size(), predict_lookup(page));
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_frame_limit(logic [CSR_WIDTH-1:0] value);
      drain_requests();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_limit_reg = value;
      limits_written++;
   endtask

   // Fill all sixteen frames from empty, hit on the least recent page of the recency order,
   // then miss so that the least recent page is evicted.
   task automatic test_fill_and_evict();
      send_page(20'h00000);
      send_page(20'hFFFFF);
      send_page(20'h00000);
      for (int i = 0; i < 14; i++) begin
         send_page(page_type'(1) << i);
      end
      send_page(20'hFFFFF);
      send_page(20'h12345);
      send_page(20'h00000);
      send_page(20'h00002);
   endtask

   // Out-of-range limits clamp: all ones acts as sixteen frames, zero as one.
   task automatic test_limit_extremes();
      write_frame_limit(5'd31);
      send_page(20'h55555);
      send_page(20'hAAAAA);
      write_frame_limit(5'd0);
      send_page(20'hAAAAA);
      send_page(20'h0F0F0);
   endtask

   // Random traffic from a small working set so that hits, misses and evictions mix,
   // with some fully random pages as noise. The sender works in bursts.
   task automatic test_random_phase(logic [CSR_WIDTH-1:0] limit, int count);
      page_type working_set [SET_MAX];
      int       set_size;
      int       burst_left;
      int       gap;
      bit       gapless;
      page_type page;
      write_frame_limit(limit);
      set_size = int'($urandom_range(2, SET_MAX));
      for (int i = 0; i < set_size; i++) begin
         case ($urandom_range(0, 9))
            0: working_set[i] = 20'h00000;
            1: working_set[i] = 20'hFFFFF;
            default: working_set[i] = page_type'($urandom_range(0, 20'hFFFFF));
         endcase
      end
      gapless = ($urandom_range(0, 3) == 0);
      burst_left = int'($urandom_range(1, 24));
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 85) begin
            page = working_set[$urandom_range(0, $urandom_range(0, set_size - 1))];
         end else begin
            page = page_type'($urandom_range(0, 20'hFFFFF));
         end
         send_page(page);
         if (burst_left == 0) begin
            gap = gapless ? 0 : int'($urandom_range(0, 8));
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = int'($urandom_range(1, 24));
         end else begin
            burst_left--;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_and_evict();
      test_limit_extremes();
      test_random_phase(5'd1, 150);
      test_random_phase(5'd16, 150);
      test_random_phase(5'd2, 150);
      test_random_phase(5'd17, 150);
      test_random_phase(CSR_WIDTH'($urandom_range(3, 15)), 150);
      test_random_phase(5'd0, 150);
      test_random_phase(5'd31, 150);
      test_random_phase(CSR_WIDTH'($urandom_range(1, 16)), 150);
      drain_requests();
      $display("Checked %0d responses (%0d hits, %0d evictions) over %0d frame limit settings.",
               responses_checked, hits_seen, evictions_seen, limits_written);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches found.", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Run timed out with %0d requests outstanding.", pending_lookups.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
sv/lrupr_pkg.sv
sv/lrupr_frame_table.sv
sv/lru_page_replacement.sv
test/tb.sv
